/* src/rmv_pkg.sv */
package rmv_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int MEAN_FRAC   = 16;
  localparam int MEAN_W      = SAMPLE_BITS + MEAN_FRAC;
  localparam int PROD_W      = 2 * MEAN_W;
  localparam int PROD_SHIFT  = 24;
  localparam int SUM_W       = 64;
  localparam int VAR_W       = 48;
  localparam int STATUS_W    = 3;
  localparam int STEP_W      = $clog2(SUM_W);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NODATA = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVF    = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/rmv_div.sv */
module rmv_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rmv_pkg::SUM_W-1:0]       dividend,
  input  logic [rmv_pkg::COUNT_BITS-1:0]  divisor,
  output logic [rmv_pkg::SUM_W-1:0]       quotient,
  output rmv_pkg::div_stat_t              stat
);

  logic                             busy;
  logic                             done;
  logic [rmv_pkg::STEP_W-1:0]       step;
  logic [rmv_pkg::COUNT_BITS-1:0]   rem;
  logic [rmv_pkg::COUNT_BITS-1:0]   dsr;
  logic [rmv_pkg::SUM_W-1:0]        quo;
  logic [rmv_pkg::COUNT_BITS+1:0]   trial;
  logic                             neg;

  // one quotient bit a cycle, restoring form
  always_comb begin
    trial = {1'b0, rem, quo[rmv_pkg::SUM_W-1]} - {2'b00, dsr};
    neg   = trial[rmv_pkg::COUNT_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + rmv_pkg::STEP_W'(1);
        if (step == rmv_pkg::STEP_W'(rmv_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      quo <= {quo[rmv_pkg::SUM_W-2:0], ~neg};
      if (neg) begin
        rem <= {rem[rmv_pkg::COUNT_BITS-2:0], quo[rmv_pkg::SUM_W-1]};
      end else begin
        rem <= trial[rmv_pkg::COUNT_BITS-1:0];
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* src/running_mean_variance.sv */
// Welford running mean and sample variance over unsigned samples. An add item
// folds one sample into the count, the Q16.16 mean and the Q.8 sum of squared
// deviations, or answers with overflow status and leaves all state alone; a
// report item returns count, mean and the Q40.8 variance (saturated) and then
// clears everything. One item is in flight at a time. An add and a report
// with two or more samples both run through the shared 64-step radix-2
// divider that serves the mean update and the variance; an add refused for a
// full count and a report with fewer than two samples bypass it. A finished
// result sits in the output register while the next item is taken.
module running_mean_variance (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [rmv_pkg::SAMPLE_BITS-1:0]  sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rmv_pkg::STATUS_W-1:0]     status,
  output logic [rmv_pkg::COUNT_BITS-1:0]   count,
  output logic [rmv_pkg::MEAN_W-1:0]       mean,
  output logic [rmv_pkg::VAR_W-1:0]        variance
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                       state;
  logic                             op;
  logic                             below;
  logic [rmv_pkg::MEAN_W-1:0]       xq;
  logic [rmv_pkg::MEAN_W-1:0]       m1;
  logic [rmv_pkg::MEAN_W-1:0]       m2;
  logic [rmv_pkg::MEAN_W-1:0]       nmean;
  logic [rmv_pkg::PROD_W-1:0]       prod;

  logic [rmv_pkg::COUNT_BITS-1:0]   sample_count;
  logic [rmv_pkg::MEAN_W-1:0]       running_mean;
  logic [rmv_pkg::SUM_W-1:0]        sum_sq_dev;

  logic [rmv_pkg::STATUS_W-1:0]     res_status;
  logic [rmv_pkg::COUNT_BITS-1:0]   res_count;
  logic [rmv_pkg::MEAN_W-1:0]       res_mean;
  logic [rmv_pkg::VAR_W-1:0]        res_var;

  logic                             in_accept;
  logic                             out_load;
  logic [rmv_pkg::MEAN_W-1:0]       xq_in;
  logic                             below_in;
  logic [rmv_pkg::MEAN_W-1:0]       m1_in;
  logic                             div_start;
  logic [rmv_pkg::SUM_W-1:0]        div_dividend;
  logic [rmv_pkg::COUNT_BITS-1:0]   div_divisor;
  logic [rmv_pkg::SUM_W-1:0]        quotient;
  rmv_pkg::div_stat_t               div_stat;
  logic [rmv_pkg::MEAN_W-1:0]       q_mean;
  logic [rmv_pkg::MEAN_W-1:0]       nmean_dv;
  logic [rmv_pkg::MEAN_W-1:0]       m2_dv;
  logic [rmv_pkg::PROD_W-1:0]       prod_sh;
  logic [rmv_pkg::SUM_W-1:0]        inc;
  logic [rmv_pkg::SUM_W:0]          sum_ext;
  logic [rmv_pkg::VAR_W-1:0]        var_sat;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    xq_in    = {sample, {rmv_pkg::MEAN_FRAC{1'b0}}};
    below_in = (xq_in < running_mean);
    m1_in    = below_in ? (running_mean - xq_in) : (xq_in - running_mean);

    div_start    = 1'b0;
    div_dividend = sum_sq_dev;
    div_divisor  = sample_count - rmv_pkg::COUNT_BITS'(1);
    if (cmd == rmv_pkg::CMD_ADD) begin
      div_dividend = rmv_pkg::SUM_W'(m1_in);
      div_divisor  = sample_count + rmv_pkg::COUNT_BITS'(1);
      div_start    = in_accept && (sample_count != '1);
    end else begin
      div_start    = in_accept && (sample_count > rmv_pkg::COUNT_BITS'(1));
    end

    // quotient never exceeds m1 on the add path
    q_mean   = quotient[rmv_pkg::MEAN_W-1:0];
    nmean_dv = below ? (running_mean - q_mean) : (running_mean + q_mean);
    m2_dv    = below ? (nmean_dv - xq) : (xq - nmean_dv);

    // the product is at most 64 bits, so after the shift it always fits
    prod_sh = prod >> rmv_pkg::PROD_SHIFT;
    inc     = rmv_pkg::SUM_W'(prod_sh);
    sum_ext = {1'b0, sum_sq_dev} + {1'b0, inc};

    var_sat = (quotient[rmv_pkg::SUM_W-1:rmv_pkg::VAR_W] != '0) ? '1
            : quotient[rmv_pkg::VAR_W-1:0];
  end

  rmv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // sequencer and statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      running_mean <= '0;
      sum_sq_dev   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= div_start ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= (op == rmv_pkg::CMD_ADD) ? S_MUL : S_OUT;
          end
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (!sum_ext[rmv_pkg::SUM_W]) begin
            sample_count <= sample_count + rmv_pkg::COUNT_BITS'(1);
            running_mean <= nmean;
            sum_sq_dev   <= sum_ext[rmv_pkg::SUM_W-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
            if (op == rmv_pkg::CMD_REPORT) begin
              sample_count <= '0;
              running_mean <= '0;
              sum_sq_dev   <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers and pending result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          op    <= cmd;
          xq    <= xq_in;
          below <= below_in;
          m1    <= m1_in;
          res_count <= sample_count;
          res_mean  <= running_mean;
          res_var   <= '0;
          if (cmd == rmv_pkg::CMD_ADD) begin
            res_status <= rmv_pkg::ST_OVF;
          end else if (sample_count == '0) begin
            res_status <= rmv_pkg::ST_NODATA;
            res_mean   <= '0;
          end else if (sample_count == rmv_pkg::COUNT_BITS'(1)) begin
            res_status <= rmv_pkg::ST_ONE;
          end else begin
            res_status <= rmv_pkg::ST_OK;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          nmean   <= nmean_dv;
          m2      <= m2_dv;
          res_var <= var_sat;
        end
      end
      S_MUL: begin
        prod <= m1 * m2;
      end
      S_UPD: begin
        if (sum_ext[rmv_pkg::SUM_W]) begin
          res_status <= rmv_pkg::ST_OVF;
        end else begin
          res_status <= rmv_pkg::ST_ADDED;
          res_count  <= sample_count + rmv_pkg::COUNT_BITS'(1);
          res_mean   <= nmean;
        end
        res_var <= '0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status   <= res_status;
      count    <= res_count;
      mean     <= res_mean;
      variance <= res_var;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  a_div_quiet_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while waiting for an item");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && (op == rmv_pkg::CMD_REPORT))
      |=> (sample_count == '0) && (running_mean == '0) && (sum_sq_dev == '0))
    else $error("report did not clear the statistics");

  a_added_count_matches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == rmv_pkg::ST_ADDED) && (state == S_IDLE))
      |-> (count == sample_count) && (variance == '0))
    else $error("added item disagrees with the stored count");

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1800;
  localparam int QUIET_TAIL  = 250;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 100;

  typedef logic [rmv_pkg::SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [rmv_pkg::STATUS_W-1:0]   status;
    logic [rmv_pkg::COUNT_BITS-1:0] count;
    logic [rmv_pkg::MEAN_W-1:0]     mean;
    logic [rmv_pkg::VAR_W-1:0]      variance;
  } stats_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           cmd = rmv_pkg::CMD_ADD;
  sample_t                        sample = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [rmv_pkg::STATUS_W-1:0]   status;
  logic [rmv_pkg::COUNT_BITS-1:0] count;
  logic [rmv_pkg::MEAN_W-1:0]     mean;
  logic [rmv_pkg::VAR_W-1:0]      variance;

  running_mean_variance DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .count     (count),
    .mean      (mean),
    .variance  (variance)
  );

  // shadow of the accumulator state
  logic [rmv_pkg::COUNT_BITS-1:0] acc_count = '0;
  logic [rmv_pkg::MEAN_W-1:0]     acc_mean  = '0;
  logic [rmv_pkg::SUM_W-1:0]      acc_sum   = '0;

  stats_t      pending_stats[$];
  int unsigned fault_count = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_left  = 0;
  bit          quiet       = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic stats_t next_stats(input logic c, input sample_t x);
    stats_t                      r;
    logic [rmv_pkg::MEAN_W:0]    am;
    logic [rmv_pkg::MEAN_W:0]    xq;
    logic [rmv_pkg::MEAN_W:0]    m1;
    logic [rmv_pkg::MEAN_W:0]    m2;
    logic [rmv_pkg::MEAN_W:0]    nmean;
    logic [rmv_pkg::MEAN_W:0]    n;
    logic [127:0]                prod;
    logic [rmv_pkg::SUM_W-1:0]   inc;
    logic [rmv_pkg::SUM_W-1:0]   quo;
    logic                        ovf;
    r = '0;
    if (c == rmv_pkg::CMD_ADD) begin
      am = {1'b0, acc_mean};
      n = (rmv_pkg::MEAN_W+1)'(acc_count) + (rmv_pkg::MEAN_W+1)'(1);
      xq = {1'b0, x, {rmv_pkg::MEAN_FRAC{1'b0}}};
      nmean = am;
      inc = '0;
      ovf = 1'b0;
      m1 = '0;
      m2 = '0;
      if (acc_count == {rmv_pkg::COUNT_BITS{1'b1}}) begin
        ovf = 1'b1;
      end else if (xq >= am) begin
        m1 = xq - am;
        nmean = am + m1 / n;
        m2 = xq - nmean;
      end else begin
        m1 = am - xq;
        nmean = am - m1 / n;
        m2 = nmean - xq;
      end
      if (!ovf) begin
        prod = 128'(m1) * 128'(m2);
        ovf = (prod[127:rmv_pkg::PROD_SHIFT+rmv_pkg::SUM_W] != '0);
        inc = prod[rmv_pkg::PROD_SHIFT+rmv_pkg::SUM_W-1:rmv_pkg::PROD_SHIFT];
        if (!ovf && inc > ~acc_sum) ovf = 1'b1;
      end
      if (ovf) begin
        r.status = rmv_pkg::ST_OVF;
      end else begin
        acc_count = n[rmv_pkg::COUNT_BITS-1:0];
        acc_mean  = nmean[rmv_pkg::MEAN_W-1:0];
        acc_sum   = acc_sum + inc;
        r.status  = rmv_pkg::ST_ADDED;
      end
      r.count = acc_count;
      r.mean  = acc_mean;
    end else begin
      r.count = acc_count;
      r.mean  = acc_mean;
      if (acc_count == '0) begin
        r.status = rmv_pkg::ST_NODATA;
        r.mean   = '0;
      end else if (acc_count == rmv_pkg::COUNT_BITS'(1)) begin
        r.status = rmv_pkg::ST_ONE;
      end else begin
        r.status = rmv_pkg::ST_OK;
        quo = acc_sum / (rmv_pkg::SUM_W'(acc_count) - rmv_pkg::SUM_W'(1));
        // variance saturates at the top of its field
        r.variance = (quo > rmv_pkg::SUM_W'({rmv_pkg::VAR_W{1'b1}})) ? '1
                   : quo[rmv_pkg::VAR_W-1:0];
      end
      acc_count = '0;
      acc_mean  = '0;
      acc_sum   = '0;
    end
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic push_item(input logic c, input sample_t x, input bit typed,
                           input stats_t want);
    stats_t predicted;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    sample   <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_stats(c, x);
    pending_stats.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
  endtask

  // random result stall bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, count, mean, variance};
      if (pending_stats.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: result with nothing expected: st=%0d cnt=%0d mean=%h var=%h",
                   $realtime, got.status, got.count, got.mean, got.variance);
      end else begin
        want = pending_stats.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.mean !== want.mean || got.variance !== want.variance) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: mismatch: want st=%0d cnt=%0d mean=%h var=%h",
                     $realtime, want.status, want.count, want.mean, want.variance);
            $display("%0t: mismatch: got  st=%0d cnt=%0d mean=%h var=%h",
                     $realtime, got.status, got.count, got.mean, got.variance);
          end
        end
      end
    end
  end

  // no item moving on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("running_mean_variance verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  typedef struct {
    logic    c;
    sample_t x;
    bit      typed;
    stats_t  want;
  } plan_row_t;

  plan_row_t plan[$];

  task automatic plan_row(input logic c, input sample_t x, input int typed,
                          input logic [rmv_pkg::STATUS_W-1:0] st,
                          input int unsigned cnt, input int unsigned mn);
    plan_row_t row;
    row.c     = c;
    row.x     = x;
    row.typed = (typed != 0);
    row.want  = '{st, rmv_pkg::COUNT_BITS'(cnt), rmv_pkg::MEAN_W'(mn), '0};
    plan.push_back(row);
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned style;
    bit          paused;
    sample_t     base;
    sample_t     x;

    paused = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // report on nothing, one sample, extremes, constant and mixed runs
    plan_row(rmv_pkg::CMD_REPORT, 16'h0000, 1, rmv_pkg::ST_NODATA, 0, 0);
    plan_row(rmv_pkg::CMD_REPORT, 16'hFFFF, 1, rmv_pkg::ST_NODATA, 0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'h0000, 1, rmv_pkg::ST_ADDED,  1, 0);
    plan_row(rmv_pkg::CMD_REPORT, 16'h0000, 1, rmv_pkg::ST_ONE,    1, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'hFFFF, 1, rmv_pkg::ST_ADDED,  1, 32'hFFFF0000);
    plan_row(rmv_pkg::CMD_REPORT, 16'h5A5A, 1, rmv_pkg::ST_ONE,    1, 32'hFFFF0000);
    plan_row(rmv_pkg::CMD_ADD,    16'h0000, 1, rmv_pkg::ST_ADDED,  1, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'hFFFF, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'h0000, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'hFFFF, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_REPORT, 16'hA5A5, 0, rmv_pkg::ST_OK,     0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'h1234, 1, rmv_pkg::ST_ADDED,  1, 32'h12340000);
    plan_row(rmv_pkg::CMD_ADD,    16'h1234, 1, rmv_pkg::ST_ADDED,  2, 32'h12340000);
    plan_row(rmv_pkg::CMD_ADD,    16'h1234, 1, rmv_pkg::ST_ADDED,  3, 32'h12340000);
    plan_row(rmv_pkg::CMD_REPORT, 16'h0000, 1, rmv_pkg::ST_OK,     3, 32'h12340000);
    plan_row(rmv_pkg::CMD_ADD,    16'hAAAA, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'h5555, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'h8000, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'h7FFF, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'h0001, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_ADD,    16'hFFFE, 0, rmv_pkg::ST_ADDED,  0, 0);
    plan_row(rmv_pkg::CMD_REPORT, 16'hFFFF, 0, rmv_pkg::ST_OK,     0, 0);
    plan_row(rmv_pkg::CMD_REPORT, 16'h0000, 1, rmv_pkg::ST_NODATA, 0, 0);

    gap_pct = 20;
    stall_pct <= 20;
    foreach (plan[i]) push_item(plan[i].c, plan[i].x, plan[i].typed, plan[i].want);

    while (items_sent < TOTAL_ITEMS) begin
      if (!paused && items_sent >= TOTAL_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if (items_sent >= TOTAL_ITEMS - QUIET_TAIL) quiet <= 1'b1;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 15;
        default: stall_pct <= 40;
      endcase

      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise: any command, any sample
        len = $urandom_range(1, 6);
        repeat (len)
          push_item(($urandom_range(0, 1) != 0) ? rmv_pkg::CMD_REPORT : rmv_pkg::CMD_ADD,
                    sample_t'($urandom()), 1'b0, '0);
      end else if (kind == 1) begin
        // at most one add then a report, too few samples unless noise left some behind
        if ($urandom_range(0, 1) != 0)
          push_item(rmv_pkg::CMD_ADD, sample_t'($urandom()), 1'b0, '0);
        push_item(rmv_pkg::CMD_REPORT, sample_t'($urandom()), 1'b0, '0);
      end else begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(150, 300) : $urandom_range(2, 40);
        style = $urandom_range(0, 3);
        base = sample_t'($urandom());
        repeat (len) begin
          case (style)
            0: x = sample_t'($urandom());
            1: x = base ^ sample_t'($urandom_range(0, 15));
            2: x = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: x = base ^ (sample_t'(1) << $urandom_range(0, rmv_pkg::SAMPLE_BITS - 1));
          endcase
          push_item(rmv_pkg::CMD_ADD, x, 1'b0, '0);
        end
        push_item(rmv_pkg::CMD_REPORT, sample_t'($urandom()), 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_stats.size() == 0) begin
      $display("running_mean_variance verification clean");
    end else begin
      $display("running_mean_variance verification failed");
    end
    $finish;
  end

endmodule
